// ===== src/four_tap_2x_upsampler_defines.svh =====
// assertion macros for the upsampler modules
`ifndef FOUR_TAP_2X_UPSAMPLER_DEFINES_SVH
`define FOUR_TAP_2X_UPSAMPLER_DEFINES_SVH

// same-cycle implication
`define FTU_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FTU_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ftu_pkg.sv =====
// shared constants, types and filter functions for the 2x upsampler
package ftu_pkg;

   localparam int MaxWidth  = 2048;
   localparam int LineRows  = 4;
   localparam int PixW      = 8;
   localparam int ColW      = $clog2(MaxWidth);
   localparam int RowW      = 12;
   localparam int WordW     = LineRows * PixW;
   localparam int WinCols   = 4;

   localparam logic CsrFrameWidth  = 1'b0;
   localparam logic CsrFrameHeight = 1'b1;

   typedef logic [PixW-1:0] pix_type;
   typedef logic [WordW-1:0] word_type;
   typedef logic [WinCols-1:0][WordW-1:0] win_type;

   typedef struct packed {
      win_type         win;
      logic [ColW-1:0] x;
      logic [RowW-1:0] y;
   } job_type;

   // (-1,9,9,-1)/16 with floor, clamped to 0..255
   function automatic pix_type taps(pix_type a, pix_type b, pix_type c, pix_type d);
      logic [12:0] sum_bc;
      logic [12:0] pos;
      logic [12:0] neg;
      logic [12:0] dif;
      sum_bc = {5'd0, b} + {5'd0, c};
      pos    = (sum_bc << 3) + sum_bc;
      neg    = {5'd0, a} + {5'd0, d};
      dif    = pos - neg;
      if (pos < neg) begin
         return '0;
      end else if (dif[12:4] > 9'd255) begin
         return 8'hFF;
      end else begin
         return dif[11:4];
      end
   endfunction

   // effective width minus one
   function automatic logic [ColW-1:0] eff_w_m1(logic [11:0] fw);
      if (fw == 12'd0) begin
         return '0;
      end else if (fw > 12'(MaxWidth)) begin
         return ColW'(MaxWidth - 1);
      end else begin
         return ColW'(fw - 12'd1);
      end
   endfunction

   // effective height minus one
   function automatic logic [RowW-1:0] eff_h_m1(logic [12:0] fh);
      if (fh == 13'd0) begin
         return '0;
      end else if (fh > 13'd4096) begin
         return 12'd4095;
      end else begin
         return 12'(fh - 13'd1);
      end
   endfunction

endpackage

// ===== src/four_tap_2x_upsampler.sv =====
// top level: frame size registers, line store pipeline and result sequencer
// path: line store read (a), merge (b), sequencer snapshot, filter e1, output register
// throughput: one result per cycle while rsp_stall is low; a pixel that completes n blocks
//    gives 4*n results, and a pixel completing no block gives none but waits for job_ready
// the sequencer sets the rate; a width shrink mid-row costs three window refill reads
// reset clears positions and pipeline valids; line store contents are not cleared
module four_tap_2x_upsampler (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ftu_pkg::pix_type req_pixel,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [12:0]      rsp_out_row,
   output logic [11:0]      rsp_out_col,
   output ftu_pkg::pix_type rsp_value,
   output logic             rsp_last,
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic [12:0]      csr_data
);
   import ftu_pkg::*;

   logic [11:0]     fw_ff, fw_in;
   logic [12:0]     fh_ff, fh_in;
   logic [ColW-1:0] w_m1;
   logic [RowW-1:0] h_m1;
   logic            job_ready, job_go;
   job_type         job;

   always_comb begin
      fw_in = fw_ff;
      fh_in = fh_ff;
      if (csr_write) begin
         case (csr_index)
            CsrFrameWidth: begin
               fw_in = csr_data[11:0];
            end
            CsrFrameHeight: begin
               fh_in = csr_data;
            end
            default: begin
               fw_in = fw_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= 12'd640;
         fh_ff <= 13'd480;
      end else begin
         fw_ff <= fw_in;
         fh_ff <= fh_in;
      end
   end

   assign w_m1 = eff_w_m1(fw_ff);
   assign h_m1 = eff_h_m1(fh_ff);

   ftu_line u_line (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_pixel (req_pixel),
      .w_m1      (w_m1),
      .h_m1      (h_m1),
      .job_ready (job_ready),
      .job_go    (job_go),
      .job       (job)
   );

   ftu_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .job_go      (job_go),
      .job         (job),
      .job_ready   (job_ready),
      .w_m1        (w_m1),
      .h_m1        (h_m1),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_out_row (rsp_out_row),
      .rsp_out_col (rsp_out_col),
      .rsp_value   (rsp_value),
      .rsp_last    (rsp_last)
   );

endmodule

// ===== src/ftu_ram.sv =====
// generic single-port-write, registered-read ram
module ftu_ram #(
   parameter int Width = 32,
   parameter int Depth = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/ftu_line.sv =====
// line store read-modify-write pipeline and column window
module ftu_line (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  ftu_pkg::pix_type        req_pixel,
   input  logic [ftu_pkg::ColW-1:0] w_m1,
   input  logic [ftu_pkg::RowW-1:0] h_m1,
   input  logic                    job_ready,
   output logic                    job_go,
   output ftu_pkg::job_type        job
);
   import ftu_pkg::*;

   logic [ColW-1:0] colpos_ff, colpos_in;
   logic [RowW-1:0] rowpos_ff, rowpos_in;
   logic [1:0]      fill_ff, fill_in;
   logic            a_vld_ff, a_vld_in;
   logic            a_dum_ff, a_dum_in;
   logic [ColW-1:0] a_x_ff, a_x_in;
   logic [RowW-1:0] a_y_ff, a_y_in;
   pix_type         a_pix_ff, a_pix_in;
   logic            a_ovr_ff, a_ovr_in;
   word_type        a_ovr_word_ff, a_ovr_word_in;
   logic            b_vld_ff, b_vld_in;
   logic            b_dum_ff, b_dum_in;
   logic [ColW-1:0] b_x_ff, b_x_in;
   logic [RowW-1:0] b_y_ff, b_y_in;
   pix_type         b_pix_ff, b_pix_in;
   word_type        b_word_ff, b_word_in;
   win_type         win_ff, win_in;

   logic [ColW-1:0] cur_x, fill_x, rd_x;
   logic [RowW-1:0] cur_y;
   logic            accept, a_move, b_go, wr_go, need_fill, slot_free, fill_go;
   word_type        rd_data, a_word, merged;
   win_type         win_new;

   assign cur_x     = (colpos_ff > w_m1) ? w_m1 : colpos_ff;
   assign cur_y     = (rowpos_ff > h_m1) ? h_m1 : rowpos_ff;
   assign b_go      = b_vld_ff & (job_ready | b_dum_ff);
   assign wr_go     = b_go & ~b_dum_ff;
   assign a_move    = a_vld_ff & (~b_vld_ff | b_go);
   assign slot_free = ~(a_vld_ff & ~a_move);
   // position past a shrunk row end: reload the three columns before it
   assign need_fill = (colpos_ff > w_m1) & (fill_ff != 2'd3);
   assign fill_go   = need_fill & slot_free;
   assign fill_x    = w_m1 - ColW'(2'd3 - fill_ff);
   assign req_stall = ~slot_free | need_fill;
   assign accept    = req_valid & ~req_stall;
   assign rd_x      = fill_go ? fill_x : cur_x;
   assign a_word    = a_ovr_ff ? a_ovr_word_ff : rd_data;

   always_comb begin
      merged = b_word_ff;
      if (!b_dum_ff) begin
         merged[b_y_ff[1:0]*PixW +: PixW] = b_pix_ff;
      end
      win_new = {win_ff[WinCols-2:0], merged};
   end

   ftu_ram #(.Width(WordW), .Depth(MaxWidth)) u_ram (
      .clock   (clock),
      .wr_en   (wr_go),
      .wr_addr (b_x_ff),
      .wr_data (merged),
      .rd_en   (accept | fill_go),
      .rd_addr (rd_x),
      .rd_data (rd_data)
   );

   always_comb begin
      colpos_in     = colpos_ff;
      rowpos_in     = rowpos_ff;
      fill_in       = fill_ff;
      a_vld_in      = a_vld_ff;
      a_dum_in      = a_dum_ff;
      a_x_in        = a_x_ff;
      a_y_in        = a_y_ff;
      a_pix_in      = a_pix_ff;
      a_ovr_in      = a_ovr_ff;
      a_ovr_word_in = a_ovr_word_ff;
      b_vld_in      = b_vld_ff;
      b_dum_in      = b_dum_ff;
      b_x_in        = b_x_ff;
      b_y_in        = b_y_ff;
      b_pix_in      = b_pix_ff;
      b_word_in     = b_word_ff;
      win_in        = win_ff;
      if (b_go) begin
         win_in   = win_new;
         b_vld_in = 1'b0;
      end
      if (a_move) begin
         b_vld_in  = 1'b1;
         b_dum_in  = a_dum_ff;
         b_x_in    = a_x_ff;
         b_y_in    = a_y_ff;
         b_pix_in  = a_pix_ff;
         b_word_in = (wr_go & (b_x_ff == a_x_ff)) ? merged : a_word;
         a_vld_in  = 1'b0;
      end
      if (fill_go) begin
         fill_in       = fill_ff + 2'd1;
         a_vld_in      = 1'b1;
         a_dum_in      = 1'b1;
         a_x_in        = fill_x;
         a_y_in        = cur_y;
         a_ovr_in      = wr_go & (b_x_ff == fill_x);
         a_ovr_word_in = merged;
      end else if (accept) begin
         a_vld_in      = 1'b1;
         a_dum_in      = 1'b0;
         a_x_in        = cur_x;
         a_y_in        = cur_y;
         a_pix_in      = req_pixel;
         a_ovr_in      = wr_go & (b_x_ff == cur_x);
         a_ovr_word_in = merged;
         if (cur_x >= w_m1) begin
            colpos_in = '0;
            rowpos_in = (cur_y >= h_m1) ? '0 : cur_y + 12'd1;
         end else begin
            colpos_in = cur_x + 11'd1;
            rowpos_in = cur_y;
         end
      end else if (a_vld_ff & wr_go & (b_x_ff == a_x_ff)) begin
         // write to the entry already being read
         a_ovr_in      = 1'b1;
         a_ovr_word_in = merged;
      end
      if (accept | (colpos_ff <= w_m1)) begin
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         colpos_ff <= '0;
         rowpos_ff <= '0;
         fill_ff   <= '0;
         a_vld_ff  <= 1'b0;
         b_vld_ff  <= 1'b0;
      end else begin
         colpos_ff <= colpos_in;
         rowpos_ff <= rowpos_in;
         fill_ff   <= fill_in;
         a_vld_ff  <= a_vld_in;
         b_vld_ff  <= b_vld_in;
      end
      a_dum_ff      <= a_dum_in;
      a_x_ff        <= a_x_in;
      a_y_ff        <= a_y_in;
      a_pix_ff      <= a_pix_in;
      a_ovr_ff      <= a_ovr_in;
      a_ovr_word_ff <= a_ovr_word_in;
      b_dum_ff      <= b_dum_in;
      b_x_ff        <= b_x_in;
      b_y_ff        <= b_y_in;
      b_pix_ff      <= b_pix_in;
      b_word_ff     <= b_word_in;
      win_ff        <= win_in;
   end

   assign job_go  = wr_go;
   assign job.win = win_new;
   assign job.x   = b_x_ff;
   assign job.y   = b_y_ff;

endmodule

// ===== src/ftu_emit.sv =====
// block sequencer and two-stage filter pipeline for the result channel
`include "four_tap_2x_upsampler_defines.svh"

module ftu_emit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     job_go,
   input  ftu_pkg::job_type         job,
   output logic                     job_ready,
   input  logic [ftu_pkg::ColW-1:0] w_m1,
   input  logic [ftu_pkg::RowW-1:0] h_m1,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [12:0]              rsp_out_row,
   output logic [11:0]              rsp_out_col,
   output ftu_pkg::pix_type         rsp_value,
   output logic                     rsp_last
);
   import ftu_pkg::*;

   logic      busy_ff, busy_in;
   job_type   snap_ff, snap_in;
   logic      rows2_ff, rows2_in;
   logic      cols2_ff, cols2_in;
   logic      ri_ff, ri_in;
   logic      ci_ff, ci_in;
   logic [1:0] k_ff, k_in;

   logic       e1_vld_ff;
   logic [12:0] e1_row_ff;
   logic [11:0] e1_col_ff;
   pix_type    e1_hv_ff [WinCols];
   logic       e1_odd_ff;
   logic       e1_last_ff;

   logic       o_vld_ff;
   logic [12:0] o_row_ff;
   logic [11:0] o_col_ff;
   pix_type    o_value_ff;
   logic       o_last_ff;

   logic            en, load, row_last, col_last, issue_last, has_blocks;
   logic [RowW-1:0] r;
   logic [ColW-1:0] c;
   logic [1:0]      slot [WinCols];
   logic [1:0]      dsel [WinCols];
   logic [1:0]      dmid;
   pix_type         px [WinCols][WinCols];
   pix_type         hv [WinCols];
   logic signed [13:0] trow, tcol;
   logic [RowW-1:0] rr;
   logic [ColW-1:0] cc;

   assign en         = ~(o_vld_ff & rsp_stall);
   assign row_last   = ~rows2_ff | ri_ff;
   assign col_last   = ~cols2_ff | ci_ff;
   assign issue_last = row_last & col_last & (k_ff == 2'd3);
   assign job_ready  = ~busy_ff | (en & issue_last);
   assign has_blocks = ((job.y != '0) | (job.y == h_m1)) & ((job.x != '0) | (job.x == w_m1));
   assign load       = job_go & has_blocks;

   always_comb begin
      busy_in  = busy_ff;
      snap_in  = snap_ff;
      rows2_in = rows2_ff;
      cols2_in = cols2_ff;
      ri_in    = ri_ff;
      ci_in    = ci_ff;
      k_in     = k_ff;
      if (busy_ff & en) begin
         if (issue_last) begin
            busy_in = 1'b0;
         end else if (k_ff == 2'd3) begin
            k_in = 2'd0;
            if (col_last) begin
               ci_in = 1'b0;
               ri_in = 1'b1;
            end else begin
               ci_in = 1'b1;
            end
         end else begin
            k_in = k_ff + 2'd1;
         end
      end
      if (load) begin
         busy_in  = 1'b1;
         snap_in  = job;
         rows2_in = (job.y != '0) & (job.y == h_m1);
         cols2_in = (job.x != '0) & (job.x == w_m1);
         ri_in    = 1'b0;
         ci_in    = 1'b0;
         k_in     = 2'd0;
      end
   end

   // block coordinates and horizontal pass over the four source rows
   always_comb begin
      r = (~ri_ff & (snap_ff.y != '0)) ? snap_ff.y - 12'd1 : snap_ff.y;
      c = (~ci_ff & (snap_ff.x != '0)) ? snap_ff.x - 11'd1 : snap_ff.x;
      for (int j = 0; j < WinCols; j++) begin
         trow = $signed({2'b00, r}) + 14'(j) - 14'sd2;
         if (trow < 0) begin
            rr = '0;
         end else if (trow > $signed({2'b00, h_m1})) begin
            rr = h_m1;
         end else begin
            rr = trow[RowW-1:0];
         end
         slot[j] = rr[1:0];
      end
      for (int i = 0; i < WinCols; i++) begin
         tcol = $signed({3'b000, c}) + 14'(i) - 14'sd2;
         if (tcol < 0) begin
            cc = '0;
         end else if (tcol > $signed({3'b000, w_m1})) begin
            cc = w_m1;
         end else begin
            cc = tcol[ColW-1:0];
         end
         dsel[i] = 2'(snap_ff.x - cc);
      end
      dmid = 2'(snap_ff.x - c);
      for (int j = 0; j < WinCols; j++) begin
         for (int i = 0; i < WinCols; i++) begin
            px[j][i] = snap_ff.win[dsel[i]][slot[j]*PixW +: PixW];
         end
         if (k_ff[0]) begin
            hv[j] = snap_ff.win[dmid][slot[j]*PixW +: PixW];
         end else begin
            hv[j] = taps(px[j][0], px[j][1], px[j][2], px[j][3]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         e1_vld_ff <= 1'b0;
         o_vld_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (en) begin
            e1_vld_ff <= busy_ff;
            o_vld_ff  <= e1_vld_ff;
         end
      end
      snap_ff  <= snap_in;
      rows2_ff <= rows2_in;
      cols2_ff <= cols2_in;
      ri_ff    <= ri_in;
      ci_ff    <= ci_in;
      k_ff     <= k_in;
      if (en) begin
         e1_row_ff  <= {r, k_ff[1]};
         e1_col_ff  <= {c, k_ff[0]};
         e1_hv_ff   <= hv;
         e1_odd_ff  <= k_ff[1];
         e1_last_ff <= issue_last;
         o_row_ff   <= e1_row_ff;
         o_col_ff   <= e1_col_ff;
         o_value_ff <= e1_odd_ff ? e1_hv_ff[2]
                                 : taps(e1_hv_ff[0], e1_hv_ff[1], e1_hv_ff[2], e1_hv_ff[3]);
         o_last_ff  <= e1_last_ff;
      end
   end

   assign rsp_valid   = o_vld_ff;
   assign rsp_out_row = o_row_ff;
   assign rsp_out_col = o_col_ff;
   assign rsp_value   = o_value_ff;
   assign rsp_last    = o_last_ff;

   `FTU_ASSERT_NOW(a_load_free, job_go, (~busy_ff || (en && issue_last)), "job taken while busy")
   `FTU_ASSERT_NOW(a_cnt_range, busy_ff, ((ri_ff <= rows2_ff) && (ci_ff <= cols2_ff)), "block index out of range")
   `FTU_ASSERT_NXT(a_done_idle, (busy_ff && en && issue_last && !load), !busy_ff, "sequencer kept running")

endmodule

// ===== bench/ftu_checker.sv =====
// checker for the 2x upsampler: predicts output pixels from accepted source pixels and compares
module ftu_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  ftu_pkg::pix_type req_pixel,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  logic [12:0]      rsp_out_row,
   input  logic [11:0]      rsp_out_col,
   input  ftu_pkg::pix_type rsp_value,
   input  logic             rsp_last,
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic [12:0]      csr_data,
   output int               pending,
   output int               errors
);
   timeunit 1ns;
   timeprecision 1ps;
   import ftu_pkg::*;

   typedef struct {
      logic [12:0] row;
      logic [11:0] col;
      pix_type     value;
      logic        last;
   } out_pix_t;

   out_pix_t     expected_pixels[$];
   logic [7:0]   lines[LineRows][MaxWidth];
   logic [11:0]  width_reg;
   logic [12:0]  height_reg;
   int           pos_x;
   int           pos_y;

   function automatic int eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MaxWidth) return MaxWidth;
      return width_reg;
   endfunction

   function automatic int eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > 4096) return 4096;
      return height_reg;
   endfunction

   function automatic int clip(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic int interp(int a, int b, int c, int d);
      int s;
      s = -a + 9 * b + 9 * c - d;
      if (s < 0) return 0;
      s = s >>> 4;
      return (s > 255) ? 255 : s;
   endfunction

   function automatic int src(int r, int c, int w, int h);
      return lines[clip(r, 0, h - 1) % LineRows][clip(c, 0, w - 1)];
   endfunction

   function automatic int odd_line(int r, int k, int w, int h);
      int c;
      c = k >> 1;
      if (k % 2 == 1) return src(r, c, w, h);
      return interp(src(r, c - 2, w, h), src(r, c - 1, w, h), src(r, c, w, h),
                    src(r, c + 1, w, h));
   endfunction

   function automatic int even_line(int r, int k, int w, int h);
      return interp(odd_line(clip(r - 2, 0, h - 1), k, w, h),
                    odd_line(clip(r - 1, 0, h - 1), k, w, h),
                    odd_line(clip(r, 0, h - 1), k, w, h),
                    odd_line(clip(r + 1, 0, h - 1), k, w, h));
   endfunction

   task automatic push_pix(int row, int col, int v);
      out_pix_t p;
      p.row   = 13'(row);
      p.col   = 12'(col);
      p.value = pix_type'(v);
      p.last  = 1'b0;
      expected_pixels.push_back(p);
   endtask

   task automatic upsample_pixel(pix_type pix);
      int w, h, x, y, nr, nc, r, c, n0;
      int rows[2];
      int cols[2];
      w  = eff_width();
      h  = eff_height();
      x  = (pos_x > w - 1) ? w - 1 : pos_x;
      y  = (pos_y > h - 1) ? h - 1 : pos_y;
      nr = 0;
      nc = 0;
      n0 = expected_pixels.size();
      lines[y % LineRows][x] = pix;
      if (y >= 1) begin rows[nr] = y - 1; nr++; end
      if (y == h - 1) begin rows[nr] = y; nr++; end
      if (x >= 1) begin cols[nc] = x - 1; nc++; end
      if (x == w - 1) begin cols[nc] = x; nc++; end
      for (int i = 0; i < nr; i++) begin
         for (int j = 0; j < nc; j++) begin
            r = rows[i];
            c = cols[j];
            push_pix(2 * r, 2 * c, even_line(r, 2 * c, w, h));
            push_pix(2 * r, 2 * c + 1, even_line(r, 2 * c + 1, w, h));
            push_pix(2 * r + 1, 2 * c, odd_line(r, 2 * c, w, h));
            push_pix(2 * r + 1, 2 * c + 1, odd_line(r, 2 * c + 1, w, h));
         end
      end
      if (expected_pixels.size() > n0) expected_pixels[$].last = 1'b1;
      if (x >= w - 1) begin
         pos_x = 0;
         pos_y = (y >= h - 1) ? 0 : y + 1;
      end else begin
         pos_x = x + 1;
         pos_y = y;
      end
   endtask

   task automatic compare_pixel();
      out_pix_t e;
      if (expected_pixels.size() == 0) begin
         $display("%0t: unexpected transaction row=%0d col=%0d value=%0d last=%0b", $time,
                  rsp_out_row, rsp_out_col, rsp_value, rsp_last);
         errors++;
      end else begin
         e = expected_pixels.pop_front();
         if (e.row !== rsp_out_row || e.col !== rsp_out_col || e.value !== rsp_value ||
             e.last !== rsp_last) begin
            $display("%0t: mismatch expected row=%0d col=%0d value=%0d last=%0b", $time,
                     e.row, e.col, e.value, e.last);
            $display("%0t:          actual   row=%0d col=%0d value=%0d last=%0b", $time,
                     rsp_out_row, rsp_out_col, rsp_value, rsp_last);
            errors++;
         end
      end
   endtask

   initial begin
      errors  = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         expected_pixels.delete();
         pos_x      = 0;
         pos_y      = 0;
         width_reg  = 12'd640;
         height_reg = 13'd480;
      end else begin
         if (rsp_valid && !rsp_stall) compare_pixel();
         if (req_valid && !req_stall) upsample_pixel(req_pixel);
         if (csr_write) begin
            if (csr_index == CsrFrameWidth) width_reg = csr_data[11:0];
            else height_reg = csr_data;
         end
      end
      pending = expected_pixels.size();
   end

endmodule

// ===== bench/tb_top.sv =====
// testbench top for the 2x upsampler: clock, reset, stimulus and verdict
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ftu_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   pix_type     req_pixel;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [12:0] rsp_out_row;
   logic [11:0] rsp_out_col;
   pix_type     rsp_value;
   logic        rsp_last;
   logic        csr_write;
   logic        csr_index;
   logic [12:0] csr_data;
   int          pending;
   int          errors;
   int          cycles;
   int          cur_w, cur_h, px, py, pixels_sent;
   bit          sender_busy, receiver_busy, long_hold;

   four_tap_2x_upsampler u_top (.*);
   ftu_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("Verification failed");
         $finish;
      end
   end

   // result side: random stalls with quiet stretches and one long hold-off
   initial begin
      int gap;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            rsp_stall <= 1'b0;
            long_hold = 0;
         end else begin
            gap = receiver_busy ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_pixel(pix_type p);
      int gap;
      gap = sender_busy ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= p;
      do @(posedge clock); while (req_stall);
      pixels_sent++;
      if (px > cur_w - 1) px = cur_w - 1;
      if (py > cur_h - 1) py = cur_h - 1;
      if (px >= cur_w - 1) begin
         px = 0;
         py = (py >= cur_h - 1) ? 0 : py + 1;
      end else begin
         px++;
      end
   endtask

   function automatic pix_type pick_pixel(int mode);
      case (mode)
         0: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         1: return $urandom_range(0, 1) ? 8'($urandom_range(240, 255)) : 8'($urandom_range(0, 15));
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic set_frame(int w, int h);
      drain();
      csr_write <= 1'b1;
      csr_index <= CsrFrameWidth;
      csr_data  <= 13'(w);
      @(posedge clock);
      csr_index <= CsrFrameHeight;
      csr_data  <= 13'(h);
      @(posedge clock);
      csr_write <= 1'b0;
      cur_w = (w[11:0] == 0) ? 1 : ((w[11:0] > MaxWidth) ? MaxWidth : int'(w[11:0]));
      cur_h = (h[12:0] == 0) ? 1 : ((h[12:0] > 4096) ? 4096 : int'(h[12:0]));
   endtask

   task automatic finish_frame(int mode);
      do send_pixel(pick_pixel(mode)); while (px != 0 || py != 0);
   endtask

   initial begin
      int mode;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_pixel   = '0;
      csr_write   = 1'b0;
      csr_index   = CsrFrameWidth;
      csr_data    = '0;
      long_hold   = 0;
      px          = 0;
      py          = 0;
      pixels_sent = 0;
      sender_busy = 1;
      receiver_busy = 1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // clamping extremes on a small frame
      set_frame(4, 3);
      send_pixel(8'h00); send_pixel(8'hFF); send_pixel(8'hFF); send_pixel(8'h00);
      send_pixel(8'hFF); send_pixel(8'h00); send_pixel(8'h00); send_pixel(8'hFF);
      send_pixel(8'h00); send_pixel(8'hFF); send_pixel(8'h55); send_pixel(8'hAA);
      // zero size registers give a one pixel frame
      set_frame(0, 0);
      send_pixel(8'h01); send_pixel(8'h80); send_pixel(8'hFE);
      set_frame(1, 2);
      finish_frame(0);
      set_frame(2, 1);
      finish_frame(0);

      // oversized height, then shrink mid-frame past the current row
      set_frame(3, 8191);
      repeat (13) send_pixel(pick_pixel(2));
      set_frame(3, 2);
      finish_frame(2);

      // oversized width, then shrink mid-row past the current column
      sender_busy = 0;
      receiver_busy = 0;
      set_frame(4095, 3);
      repeat (5) send_pixel(pick_pixel(2));
      set_frame(3, 1);
      finish_frame(2);

      // long receiver hold-off while source keeps coming
      set_frame(40, 4);
      long_hold = 1;
      finish_frame(2);
      sender_busy = 1;
      receiver_busy = 1;

      while (pixels_sent < 370) begin
         mode = $urandom_range(0, 4);
         sender_busy   = ($urandom_range(0, 3) != 0);
         receiver_busy = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 7))
            0: set_frame($urandom_range(0, 2), $urandom_range(0, 4));
            1: set_frame($urandom_range(3, 6), $urandom_range(0, 2));
            default: set_frame($urandom_range(3, 9), $urandom_range(3, 7));
         endcase
         finish_frame(mode);
      end

      drain();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/ftu_pkg.sv
src/ftu_ram.sv
src/ftu_line.sv
src/ftu_emit.sv
src/four_tap_2x_upsampler.sv
bench/ftu_checker.sv
bench/tb_top.sv
